// File: hdl/accalu_pkg.sv
// Shared types and action codes for the accumulator ALU.
// No dependencies; used by accalu_core and accumulator_alu_with_flags.
`timescale 1ns / 1ps

package accalu_pkg;

	// Action codes carried on the action field
	localparam logic [4:0] ACT_ADD  = 5'd0;
	localparam logic [4:0] ACT_ADC  = 5'd1;
	localparam logic [4:0] ACT_SUB  = 5'd2;
	localparam logic [4:0] ACT_SBC  = 5'd3;
	localparam logic [4:0] ACT_AND  = 5'd4;
	localparam logic [4:0] ACT_XOR  = 5'd5;
	localparam logic [4:0] ACT_OR   = 5'd6;
	localparam logic [4:0] ACT_CP   = 5'd7;
	localparam logic [4:0] ACT_INC  = 5'd8;
	localparam logic [4:0] ACT_DEC  = 5'd9;
	localparam logic [4:0] ACT_DAA  = 5'd10;
	localparam logic [4:0] ACT_CPL  = 5'd11;
	localparam logic [4:0] ACT_SCF  = 5'd12;
	localparam logic [4:0] ACT_CCF  = 5'd13;
	localparam logic [4:0] ACT_RLCA = 5'd14;
	localparam logic [4:0] ACT_RRCA = 5'd15;
	localparam logic [4:0] ACT_RLA  = 5'd16;
	localparam logic [4:0] ACT_RRA  = 5'd17;
	localparam logic [4:0] ACT_LOAD = 5'd18;

	// Decimal adjust constants
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_MAX = 8'h99;
	localparam logic [3:0] DAA_LO_MAX = 4'h9;

	// Processor flags
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

// File: hdl/accumulator_alu_with_flags.sv
// Accumulator ALU with Z, N, H and C flags: input register, ALU, result register.
// Data path: an accepted item moves from the input register into the result
// register, which raises out_valid; it leaves when out_stall is low.
// Throughput: one item per cycle while out_stall is low; accumulator and flags
// update as the item moves from the input stage into the result register.
// Reset: arst_n clears accumulator, flags and both stage valid bits at once.
`timescale 1ns / 1ps

module accumulator_alu_with_flags (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] action,
	input  logic [7:0] operand,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] result_byte,
	output logic       zero_flag,
	output logic       flag_subtract,
	output logic       flag_half_carry,
	output logic       carry_flag
);

	logic               valid_s1;
	logic [4:0]         action_s1;
	logic [7:0]         operand_s1;
	logic               valid_s2;
	logic [7:0]         result_s2;
	accalu_pkg::flags_t flags_s2;
	logic [7:0]         acc_q;
	accalu_pkg::flags_t flags_q;

	logic               advance_s1;
	logic [7:0]         acc_next;
	accalu_pkg::flags_t flags_next;
	logic [7:0]         result_next;

	// Advance stage one when the result register is free or draining
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	// Hold the accepted item in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1  <= action;
			operand_s1 <= operand;
		end
	end

	accalu_core u_core (
		.action     (action_s1),
		.operand    (operand_s1),
		.acc        (acc_q),
		.flags      (flags_q),
		.acc_next   (acc_next),
		.flags_next (flags_next),
		.result     (result_next)
	);

	// Commit architectural state as each item leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 8'd0;
			flags_q <= '0;
		end else if (advance_s1) begin
			acc_q   <= acc_next;
			flags_q <= flags_next;
		end
	end

	// Result register: load on advance, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result_next;
			flags_s2  <= flags_next;
		end
	end

	assign out_valid       = valid_s2;
	assign result_byte     = result_s2;
	assign zero_flag       = flags_s2.z;
	assign flag_subtract   = flags_s2.n;
	assign flag_half_carry = flags_s2.h;
	assign carry_flag      = flags_s2.c;

endmodule

// File: hdl/accalu_core.sv
// Combinational ALU datapath: one action applied to accumulator and flags.
// Depends on accalu_pkg for action codes and the flag struct.
`timescale 1ns / 1ps

module accalu_core (
	input  logic [4:0]          action,
	input  logic [7:0]          operand,
	input  logic [7:0]          acc,
	input  accalu_pkg::flags_t  flags,
	output logic [7:0]          acc_next,
	output accalu_pkg::flags_t  flags_next,
	output logic [7:0]          result
);

	logic       cin_add;
	logic       cin_sub;
	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] diff9;
	logic [4:0] diff_lo;
	logic [7:0] inc_val;
	logic [7:0] dec_val;
	logic       daa_c;
	logic [7:0] daa_hi;
	logic [7:0] daa_lo;
	logic [7:0] daa_val;
	logic [7:0] logic_val;

	// Build adder, subtractor and unit increment and decrement results
	always_comb begin
		cin_add = (action == accalu_pkg::ACT_ADC) ? flags.c : 1'b0;
		cin_sub = (action == accalu_pkg::ACT_SBC) ? flags.c : 1'b0;
		sum9    = {1'b0, acc} + {1'b0, operand} + {8'd0, cin_add};
		sum_lo  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin_add};
		diff9   = {1'b0, acc} - {1'b0, operand} - {8'd0, cin_sub};
		diff_lo = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin_sub};
		inc_val = operand + 8'd1;
		dec_val = operand - 8'd1;
	end

	// Decimal adjust: both tests look at the original accumulator
	always_comb begin
		if (flags.n) begin
			daa_c   = flags.c;
			daa_hi  = flags.c ? accalu_pkg::DAA_HI_ADJ : 8'd0;
			daa_lo  = flags.h ? accalu_pkg::DAA_LO_ADJ : 8'd0;
			daa_val = acc - daa_hi - daa_lo;
		end else begin
			daa_c   = flags.c || (acc > accalu_pkg::DAA_HI_MAX);
			daa_hi  = daa_c ? accalu_pkg::DAA_HI_ADJ : 8'd0;
			daa_lo  = (flags.h || (acc[3:0] > accalu_pkg::DAA_LO_MAX)) ?
				accalu_pkg::DAA_LO_ADJ : 8'd0;
			daa_val = acc + daa_hi + daa_lo;
		end
	end

	// Select the new accumulator, flags and result byte
	always_comb begin
		acc_next   = acc;
		flags_next = flags;
		logic_val  = acc;
		unique case (action) inside
			accalu_pkg::ACT_ADD, accalu_pkg::ACT_ADC: begin
				acc_next   = sum9[7:0];
				flags_next = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
			end
			accalu_pkg::ACT_SUB, accalu_pkg::ACT_SBC: begin
				acc_next   = diff9[7:0];
				flags_next = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
			end
			accalu_pkg::ACT_CP: begin
				flags_next = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
			end
			accalu_pkg::ACT_AND: begin
				logic_val  = acc & operand;
				acc_next   = logic_val;
				flags_next = '{z: (logic_val == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			accalu_pkg::ACT_XOR: begin
				logic_val  = acc ^ operand;
				acc_next   = logic_val;
				flags_next = '{z: (logic_val == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			accalu_pkg::ACT_OR: begin
				logic_val  = acc | operand;
				acc_next   = logic_val;
				flags_next = '{z: (logic_val == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			accalu_pkg::ACT_INC: begin
				flags_next = '{z: (inc_val == 8'd0), n: 1'b0,
					h: (operand[3:0] == 4'hF), c: flags.c};
			end
			accalu_pkg::ACT_DEC: begin
				flags_next = '{z: (dec_val == 8'd0), n: 1'b1,
					h: (operand[3:0] == 4'h0), c: flags.c};
			end
			accalu_pkg::ACT_DAA: begin
				acc_next   = daa_val;
				flags_next = '{z: (daa_val == 8'd0), n: flags.n, h: 1'b0, c: daa_c};
			end
			accalu_pkg::ACT_CPL: begin
				acc_next   = ~acc;
				flags_next = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
			end
			accalu_pkg::ACT_SCF: begin
				flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			accalu_pkg::ACT_CCF: begin
				flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
			end
			accalu_pkg::ACT_RLCA: begin
				acc_next   = {acc[6:0], acc[7]};
				flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
			end
			accalu_pkg::ACT_RRCA: begin
				acc_next   = {acc[0], acc[7:1]};
				flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
			end
			accalu_pkg::ACT_RLA: begin
				acc_next   = {acc[6:0], flags.c};
				flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
			end
			accalu_pkg::ACT_RRA: begin
				acc_next   = {flags.c, acc[7:1]};
				flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
			end
			accalu_pkg::ACT_LOAD: begin
				acc_next = operand;
			end
			default: begin
				// unused codes keep all state
				acc_next   = acc;
				flags_next = flags;
			end
		endcase
	end

	// Increment and decrement report the changed operand, all else the accumulator
	always_comb begin
		case (action)
			accalu_pkg::ACT_INC: result = inc_val;
			accalu_pkg::ACT_DEC: result = dec_val;
			default:             result = acc_next;
		endcase
	end

endmodule

// File: tb/tb_top.sv
// Self-checking bench for accumulator_alu_with_flags: ALU actions, flags and
// handshake behavior, checked against a cycle-free model of the ALU state.
// Depends on accalu_pkg and the accumulator_alu_with_flags RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0]         res;
		accalu_pkg::flags_t fl;
	} alu_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [4:0] action = '0;
	logic [7:0] operand = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] result_byte;
	logic       zero_flag;
	logic       flag_subtract;
	logic       flag_half_carry;
	logic       carry_flag;

	// ALU model state
	logic [7:0]         acc_model = '0;
	accalu_pkg::flags_t flags_model = '0;

	alu_out_t   pending_alu_out[$];
	int         err_count = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_cycles = 0;

	accumulator_alu_with_flags dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.operand        (operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_byte    (result_byte),
		.zero_flag      (zero_flag),
		.flag_subtract  (flag_subtract),
		.flag_half_carry(flag_half_carry),
		.carry_flag     (carry_flag)
	);

	always #10 clk = ~clk;

	// Apply one action to the model state and return the result it produces
	function automatic alu_out_t alu_compute(input logic [4:0] act, input logic [7:0] opd);
		logic [7:0]         a;
		logic [7:0]         r;
		logic [8:0]         wide;
		logic [4:0]         nib;
		logic               cin;
		accalu_pkg::flags_t f;
		alu_out_t           o;
		a = acc_model;
		f = flags_model;
		r = a;
		case (act)
			accalu_pkg::ACT_ADD, accalu_pkg::ACT_ADC: begin
				cin = (act == accalu_pkg::ACT_ADC) ? flags_model.c : 1'b0;
				wide = {1'b0, a} + {1'b0, opd} + {8'd0, cin};
				nib = {1'b0, a[3:0]} + {1'b0, opd[3:0]} + {4'd0, cin};
				a = wide[7:0];
				f.z = (a == 8'h00);
				f.n = 1'b0;
				f.h = nib[4];
				f.c = wide[8];
			end
			accalu_pkg::ACT_SUB, accalu_pkg::ACT_SBC, accalu_pkg::ACT_CP: begin
				cin = (act == accalu_pkg::ACT_SBC) ? flags_model.c : 1'b0;
				// bit 8 and bit 4 catch the borrows
				wide = {1'b0, a} - {1'b0, opd} - {8'd0, cin};
				nib = {1'b0, a[3:0]} - {1'b0, opd[3:0]} - {4'd0, cin};
				r = wide[7:0];
				f.z = (r == 8'h00);
				f.n = 1'b1;
				f.h = nib[4];
				f.c = wide[8];
				// compare leaves the accumulator alone
				if (act != accalu_pkg::ACT_CP)
					a = r;
			end
			accalu_pkg::ACT_AND: begin
				a = a & opd;
				f = '{z: (a == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			accalu_pkg::ACT_XOR: begin
				a = a ^ opd;
				f = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			accalu_pkg::ACT_OR: begin
				a = a | opd;
				f = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			accalu_pkg::ACT_INC: begin
				r = opd + 8'h01;
				f.z = (r == 8'h00);
				f.n = 1'b0;
				f.h = (opd[3:0] == 4'hF);
			end
			accalu_pkg::ACT_DEC: begin
				r = opd - 8'h01;
				f.z = (r == 8'h00);
				f.n = 1'b1;
				f.h = (opd[3:0] == 4'h0);
			end
			accalu_pkg::ACT_DAA: begin
				// both correction tests look at the accumulator before adjust
				r = a;
				if (f.n) begin
					if (f.c)
						r = r - 8'h60;
					if (f.h)
						r = r - 8'h06;
				end else begin
					if (f.c || a > 8'h99) begin
						r = r + 8'h60;
						f.c = 1'b1;
					end
					if (f.h || a[3:0] > 4'h9)
						r = r + 8'h06;
				end
				a = r;
				f.z = (a == 8'h00);
				f.h = 1'b0;
			end
			accalu_pkg::ACT_CPL: begin
				a = ~a;
				f.n = 1'b1;
				f.h = 1'b1;
			end
			accalu_pkg::ACT_SCF: begin
				f = '{z: flags_model.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			accalu_pkg::ACT_CCF: begin
				f = '{z: flags_model.z, n: 1'b0, h: 1'b0, c: ~flags_model.c};
			end
			accalu_pkg::ACT_RLCA: begin
				f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
				a = {a[6:0], a[7]};
			end
			accalu_pkg::ACT_RRCA: begin
				f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
				a = {a[0], a[7:1]};
			end
			accalu_pkg::ACT_RLA: begin
				f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
				a = {a[6:0], flags_model.c};
			end
			accalu_pkg::ACT_RRA: begin
				f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
				a = {flags_model.c, a[7:1]};
			end
			accalu_pkg::ACT_LOAD: begin
				a = opd;
			end
			default: begin
				// unused codes: state held, result is the accumulator
			end
		endcase
		o.res = (act == accalu_pkg::ACT_INC || act == accalu_pkg::ACT_DEC) ? r : a;
		o.fl = f;
		acc_model = a;
		flags_model = f;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Predict on every input transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_alu_out.push_back(alu_compute(action, operand));
	end

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		alu_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_alu_out.size() == 0) begin
				report_mismatch($sformatf("result %02h with nothing outstanding", result_byte));
			end else begin
				want = pending_alu_out.pop_front();
				if (result_byte !== want.res)
					report_mismatch($sformatf("result_byte %02h, want %02h",
						result_byte, want.res));
				if (zero_flag !== want.fl.z)
					report_mismatch($sformatf("zero_flag %b, want %b", zero_flag, want.fl.z));
				if (flag_subtract !== want.fl.n)
					report_mismatch($sformatf("flag_subtract %b, want %b",
						flag_subtract, want.fl.n));
				if (flag_half_carry !== want.fl.h)
					report_mismatch($sformatf("flag_half_carry %b, want %b",
						flag_half_carry, want.fl.h));
				if (carry_flag !== want.fl.c)
					report_mismatch($sformatf("carry_flag %b, want %b", carry_flag, want.fl.c));
			end
		end
	end

	// Drive the output stall: long hold-off when requested, else random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("accumulator_alu_with_flags: mismatch");
			$finish;
		end
	end

	// Offer one item, with a random gap first, and hold it until the transfer
	task automatic send_op(input logic [4:0] act, input logic [7:0] opd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		operand <= opd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_alu_out.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h0F;
			3: return 8'hF0;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_bcd();
		return {4'($urandom_range(9)), 4'($urandom_range(9))};
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		send_op(accalu_pkg::ACT_LOAD, 8'h00);
		send_op(accalu_pkg::ACT_ADD, 8'h00);
		send_op(accalu_pkg::ACT_LOAD, 8'hFF);
		send_op(accalu_pkg::ACT_ADD, 8'h01);
		send_op(accalu_pkg::ACT_ADC, 8'hFF);
		send_op(accalu_pkg::ACT_SUB, 8'h01);
		send_op(accalu_pkg::ACT_SBC, 8'hFF);
		// compare must keep the accumulator
		send_op(accalu_pkg::ACT_CP, 8'hFF);
		send_op(accalu_pkg::ACT_AND, 8'h0F);
		send_op(accalu_pkg::ACT_XOR, 8'h0F);
		send_op(accalu_pkg::ACT_OR, 8'hF0);
		send_op(accalu_pkg::ACT_INC, 8'hFF);
		send_op(accalu_pkg::ACT_DEC, 8'h00);
		// decimal adjust after an add, then on a high accumulator
		send_op(accalu_pkg::ACT_LOAD, 8'h45);
		send_op(accalu_pkg::ACT_ADD, 8'h38);
		send_op(accalu_pkg::ACT_DAA, 8'h00);
		send_op(accalu_pkg::ACT_LOAD, 8'h9A);
		send_op(accalu_pkg::ACT_DAA, 8'h00);
		// decimal adjust after a subtract with both borrows
		send_op(accalu_pkg::ACT_SUB, 8'h01);
		send_op(accalu_pkg::ACT_DAA, 8'h00);
		send_op(accalu_pkg::ACT_CPL, 8'h00);
		send_op(accalu_pkg::ACT_SCF, 8'h00);
		send_op(accalu_pkg::ACT_RLA, 8'h00);
		send_op(accalu_pkg::ACT_RRA, 8'h00);
		send_op(accalu_pkg::ACT_CCF, 8'h00);
		send_op(accalu_pkg::ACT_RLCA, 8'h00);
		send_op(accalu_pkg::ACT_RRCA, 8'h00);
		send_op(5'd19, 8'hFF);
		send_op(5'd31, 8'h00);
		wait_results_done();
	endtask

	// Random traffic: mostly valid actions, some decimal sequences, a few unused codes
	task automatic test_random(input int count, input int idle_pct, input int stall_p);
		int sent;
		int sel;
		sent = 0;
		send_idle_pct = idle_pct;
		stall_pct = stall_p;
		while (sent < count) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				send_op(accalu_pkg::ACT_LOAD, pick_bcd());
				send_op($urandom_range(1) ? accalu_pkg::ACT_ADD : accalu_pkg::ACT_SUB,
					pick_bcd());
				send_op(accalu_pkg::ACT_DAA, 8'($urandom_range(255)));
				sent += 3;
			end else if (sel < 13) begin
				send_op(5'($urandom_range(31, 19)), 8'($urandom_range(255)));
				sent++;
			end else begin
				send_op(5'($urandom_range(18)), pick_operand());
				sent++;
			end
		end
		wait_results_done();
	endtask

	// Hold the output off long enough that the block fills and stalls its input
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 200;
		for (i = 0; i < 40; i++)
			send_op(5'($urandom_range(18)), pick_operand());
		wait_results_done();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(330, 0, 0);
		test_random(320, 54, 0);
		test_random(320, 0, 54);
		test_random(320, 35, 35);
		test_backpressure();
		wait_results_done();
		if (pending_alu_out.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_alu_out.size()));
		if (err_count == 0)
			$display("accumulator_alu_with_flags: match");
		else
			$display("accumulator_alu_with_flags: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hdl/accalu_pkg.sv
hdl/accalu_core.sv
hdl/accumulator_alu_with_flags.sv
tb/tb_top.sv
